### rtl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg: shared constants and types of the grid path counter
// Sizes of the line store and of the counts, register indexes, and the
// structs that carry control between the top level, the chain and its cells.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int MAX_COLS    = 128;
    localparam int COUNT_WIDTH = 32;

    // Column index and ring length widths follow from the line store depth.
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LEN_W = $clog2(MAX_COLS + 1);

    localparam int ROWS_W      = 16;
    localparam int COLS_CFG_W  = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 8;
    localparam int PATH_W      = 32;
    localparam int CMP_W       = (LEN_W > COLS_CFG_W) ? LEN_W : COLS_CFG_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS = CFG_ADDR_W'(1);

    typedef struct packed {
        logic                   sat;
        logic [COUNT_WIDTH-1:0] cnt;
    } count_val_t;

    typedef struct packed {
        logic en;
        logic tail;
    } cell_ctrl_t;

    typedef struct packed {
        logic             shift;
        logic             rotate;
        logic [LEN_W-1:0] len;
    } chain_ctrl_t;

endpackage

### rtl/gpc_cell.sv
// ----------------------------------------------------------------------------
// gpc_cell: one entry of the line store chain
// Holds one count with its saturation mark. When enabled it takes the value
// of its neighbor, or the feed value when it is the tail of the ring.
// ----------------------------------------------------------------------------
module gpc_cell (
    input  logic                aclk,
    input  gpc_pkg::cell_ctrl_t ctrl,
    input  gpc_pkg::count_val_t nbr,
    input  gpc_pkg::count_val_t feed,
    output gpc_pkg::count_val_t q
);
    import gpc_pkg::*;

    count_val_t val_reg;
    count_val_t val_next;

    always_comb begin
        val_next = val_reg;
        if (ctrl.en) begin
            val_next = ctrl.tail ? feed : nbr;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

### rtl/gpc_chain.sv
// ----------------------------------------------------------------------------
// gpc_chain: line store built as a ring of cells
// Cell 0 holds the count of the row above for the next column when aligned. On a
// shift the new count enters at the tail of the ring; on a rotate the head
// wraps around to the tail. Cells beyond the ring length hold their values.
// ----------------------------------------------------------------------------
module gpc_chain (
    input  logic                 aclk,
    input  gpc_pkg::chain_ctrl_t ctrl,
    input  gpc_pkg::count_val_t  new_val,
    output gpc_pkg::count_val_t  head
);
    import gpc_pkg::*;

    count_val_t q [MAX_COLS];
    count_val_t feed;

    assign feed = ctrl.shift ? new_val : q[0];
    assign head = q[0];

    for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
        cell_ctrl_t cc;
        count_val_t nbr;

        assign cc.en   = (ctrl.shift | ctrl.rotate) & (LEN_W'(j) < ctrl.len);
        assign cc.tail = (LEN_W'(j) == (ctrl.len - LEN_W'(1)));

        if (j == MAX_COLS - 1) begin : g_last
            assign nbr = feed;
        end else begin : g_mid
            assign nbr = q[j+1];
        end

        gpc_cell u_cell (
            .aclk (aclk),
            .ctrl (cc),
            .nbr  (nbr),
            .feed (feed),
            .q    (q[j])
        );
    end

endmodule

### rtl/grid_path_count_obstacles_unit.sv
// ----------------------------------------------------------------------------
// grid_path_count_obstacles_unit: path counter for grids with obstacles
// Counts monotone right/down paths from the top-left to the bottom-right cell.
// ----------------------------------------------------------------------------
// Grid cells arrive on the s_ channel in row-major order, top-left first, one
// per transfer; s_blocked marks an obstacle. One cell is taken per cycle while
// s_ready is high. The bottom-right cell of each grid produces one result on
// the m_ channel, registered in the cycle after that cell's transfer; all other
// cells produce none. After the last cell the row and column counters restart.
// The column counts of the row above live in a ring of cells; while it is aligned
// cell 0 presents the count above the next column, so each cell costs one add.
// Grid size is set through cfg_wr_en/cfg_addr/cfg_wdata (grid_rows at index
// 0, grid_cols at index 1). A change of grid_cols realigns the ring, one
// rotation per cycle, during which s_ready is low.
// Reset clears the counters and sets both sizes to one; line store contents
// stay undefined until written. A stalled receiver holds its result while one
// more result can be parked in a skid register; input stalls when both are
// full, and also while the ring realigns.
// ----------------------------------------------------------------------------
module grid_path_count_obstacles_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_blocked,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gpc_pkg::PATH_W-1:0]       m_path_count,
    output logic                             m_saturated
);
    import gpc_pkg::*;

    logic [ROWS_W-1:0]     grid_rows_reg;
    logic [COLS_CFG_W-1:0] grid_cols_reg;
    logic [COL_W-1:0]      col_index_reg, col_index_next;
    logic [ROWS_W-1:0]     row_index_reg, row_index_next;
    count_val_t            left_reg, left_next;
    logic [LEN_W-1:0]      ring_len_reg, ring_len_next;
    logic [COL_W-1:0]      phase_reg, phase_next;

    logic                  m_valid_reg, m_valid_next;
    count_val_t            out_reg, out_next;
    logic                  skid_valid_reg, skid_valid_next;
    count_val_t            skid_reg, skid_next;

    logic [CMP_W-1:0]      cols_raw;
    logic [LEN_W-1:0]      cols_eff;
    logic [COL_W-1:0]      col_eff;
    logic [ROWS_W-1:0]     rows_eff;
    logic                  last_col, last_row;
    logic                  aligned, relen, rot, acc, push, pop;
    count_val_t            up_val, lf_val, here, chain_head;
    logic [COUNT_WIDTH:0]  sum;
    chain_ctrl_t           chain_ctrl;

    // Effective sizes: zero acts as one, columns clip at the line store depth.
    assign cols_raw = CMP_W'(grid_cols_reg);
    always_comb begin
        if (cols_raw == '0) begin
            cols_eff = LEN_W'(1);
        end else if (cols_raw > CMP_W'(MAX_COLS)) begin
            cols_eff = LEN_W'(MAX_COLS);
        end else begin
            cols_eff = LEN_W'(cols_raw);
        end
    end

    assign rows_eff = (grid_rows_reg == '0) ? ROWS_W'(1) : grid_rows_reg;
    assign col_eff  = (LEN_W'(col_index_reg) >= cols_eff) ?
                      COL_W'(cols_eff - LEN_W'(1)) : col_index_reg;
    assign last_col = (LEN_W'(col_eff) == (cols_eff - LEN_W'(1)));
    assign last_row = (({1'b0, row_index_reg} + (ROWS_W+1)'(1)) >= {1'b0, rows_eff});

    // The ring is aligned when its length is the column count and its head
    // is the current column. A length change happens only at phase zero,
    // where cell j holds column j whatever the length.
    assign aligned = (ring_len_reg == cols_eff) && (phase_reg == col_eff);
    assign relen   = !aligned && (ring_len_reg != cols_eff) && (phase_reg == '0);
    assign rot     = !aligned && !relen;

    assign s_ready = aligned && !skid_valid_reg;
    assign acc     = s_valid && s_ready;
    assign push    = acc && last_col && last_row;
    assign pop     = m_valid_reg && m_ready;

    // Cell count: zero for an obstacle, one at the start, else above plus left.
    assign up_val = (row_index_reg != '0) ? chain_head : '0;
    assign lf_val = (col_eff != '0) ? left_reg : '0;
    assign sum    = {1'b0, up_val.cnt} + {1'b0, lf_val.cnt};

    always_comb begin
        if (s_blocked) begin
            here = '0;
        end else if (row_index_reg == '0 && col_eff == '0) begin
            here.sat = 1'b0;
            here.cnt = COUNT_WIDTH'(1);
        end else begin
            here.sat = up_val.sat | lf_val.sat | sum[COUNT_WIDTH];
            here.cnt = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        end
    end

    assign chain_ctrl.shift  = acc;
    assign chain_ctrl.rotate = rot;
    assign chain_ctrl.len    = ring_len_reg;

    gpc_chain u_chain (
        .aclk    (aclk),
        .ctrl    (chain_ctrl),
        .new_val (here),
        .head    (chain_head)
    );

    always_comb begin
        col_index_next = col_index_reg;
        row_index_next = row_index_reg;
        left_next      = left_reg;
        ring_len_next  = ring_len_reg;
        phase_next     = phase_reg;

        if (acc) begin
            if (last_col) begin
                col_index_next = '0;
                phase_next     = '0;
                left_next      = '0;
                row_index_next = last_row ? '0 : row_index_reg + ROWS_W'(1);
            end else begin
                col_index_next = col_eff + COL_W'(1);
                phase_next     = col_eff + COL_W'(1);
                left_next      = here;
            end
        end else if (relen) begin
            ring_len_next = cols_eff;
        end else if (rot) begin
            phase_next = (LEN_W'(phase_reg) == (ring_len_reg - LEN_W'(1))) ?
                         '0 : phase_reg + COL_W'(1);
        end
    end

    // Result register with one skid entry behind it.
    always_comb begin
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                out_next     = here;
                m_valid_next = 1'b1;
            end else begin
                skid_next       = here;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg  <= ROWS_W'(1);
            grid_cols_reg  <= COLS_CFG_W'(1);
            col_index_reg  <= '0;
            row_index_reg  <= '0;
            left_reg       <= '0;
            ring_len_reg   <= LEN_W'(1);
            phase_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_addr == CFG_GRID_ROWS) begin
                grid_rows_reg <= cfg_wdata[ROWS_W-1:0];
            end
            if (cfg_wr_en && cfg_addr == CFG_GRID_COLS) begin
                grid_cols_reg <= cfg_wdata[COLS_CFG_W-1:0];
            end
            col_index_reg  <= col_index_next;
            row_index_reg  <= row_index_next;
            left_reg       <= left_next;
            ring_len_reg   <= ring_len_next;
            phase_reg      <= phase_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_path_count = PATH_W'(out_reg.cnt);
    assign m_saturated  = out_reg.sat;

    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid without a result in the output register");

    // The ring head position always lies inside the ring.
    a_phase_in_ring : assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_len_reg != '0) && (LEN_W'(phase_reg) < ring_len_reg)
        && (ring_len_reg <= LEN_W'(MAX_COLS)))
        else $error("ring phase or length out of range");

    // A result that meets a stalled output register must land in the skid.
    a_push_to_skid : assert property (@(posedge aclk) disable iff (!aresetn)
        push && m_valid_reg && !m_ready |=> skid_valid_reg && m_valid_reg)
        else $error("result lost while the receiver stalled");

    // The length changes only when cell j holds column j.
    a_relen_at_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_len_next != ring_len_reg) |-> (phase_reg == '0) && !acc)
        else $error("ring length changed away from phase zero");

endmodule
